>>> rtl/core/tmfc_pkg.sv
package tmfc_pkg;

    localparam int SAMPLES_PER_ROUND = 7;
    localparam int SAMPLE_W = 12;
    localparam int IDX_W = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int ACC_W = 48;
    localparam int PROD_W = 45;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SAMPLES_PER_ROUND - 1);

    localparam logic [2:0] REG_CXX = 3'd0;
    localparam logic [2:0] REG_CXY = 3'd1;
    localparam logic [2:0] REG_OX  = 3'd2;
    localparam logic [2:0] REG_CYX = 3'd3;
    localparam logic [2:0] REG_CYY = 3'd4;
    localparam logic [2:0] REG_OY  = 3'd5;

    localparam logic signed [31:0] CXX_RESET = -32'sd5777;
    localparam logic signed [31:0] CXY_RESET = 32'sd32;
    localparam logic signed [31:0] OX_RESET  = 32'sd21560689;
    localparam logic signed [31:0] CYX_RESET = -32'sd38;
    localparam logic signed [31:0] CYY_RESET = -32'sd4256;
    localparam logic signed [31:0] OY_RESET  = 32'sd16920281;

    typedef struct packed {
        logic [7:0] x_high_byte;
        logic [7:0] x_low_byte;
        logic [7:0] y_high_byte;
        logic [7:0] y_low_byte;
        logic       pen_down;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] x_coord;
        logic signed [15:0] y_coord;
        logic               touched;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] coef_x_from_x;
        logic signed [31:0] coef_x_from_y;
        logic signed [31:0] offset_x;
        logic signed [31:0] coef_y_from_x;
        logic signed [31:0] coef_y_from_y;
        logic signed [31:0] offset_y;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_STORE,
        OP_END_FIRST,
        OP_END_SECOND,
        OP_PEN_UP_LAST
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [IDX_W-1:0]    idx;
        logic [SAMPLE_W-1:0] x_sample;
        logic [SAMPLE_W-1:0] y_sample;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEDIAN,
        ST_ROUTE,
        ST_MUL,
        ST_ACC,
        ST_FINAL,
        ST_EMIT
    } back_state_t;

    function automatic logic [SAMPLE_W-1:0] to_sample(input logic [7:0] hi,
                                                      input logic [7:0] lo);
        return {hi[6:0], lo[7:3]};
    endfunction

endpackage

>>> rtl/core/tmfc_front.sv
module tmfc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmfc_pkg::in_item_t s_data,
    input  logic              q_full,
    output logic              q_push,
    output tmfc_pkg::cmd_t    q_cmd
);
    import tmfc_pkg::*;

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             round_reg, round_next;
    logic             accept;
    logic             last_item;
    logic [IDX_W-1:0] slot;

    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign last_item = round_reg && (idx_reg >= LAST_IDX);
    assign slot      = (idx_reg > LAST_IDX) ? '0 : idx_reg;

    always_comb begin
        idx_next       = idx_reg;
        round_next     = round_reg;
        q_push         = 1'b0;
        q_cmd.op       = OP_STORE;
        q_cmd.idx      = slot;
        q_cmd.x_sample = to_sample(s_data.x_high_byte, s_data.x_low_byte);
        q_cmd.y_sample = to_sample(s_data.y_high_byte, s_data.y_low_byte);
        if (accept) begin
            if (!s_data.pen_down) begin
                // A lifted pen throws the collection away; only the final item reports it.
                idx_next   = '0;
                round_next = 1'b0;
                q_push     = last_item;
                q_cmd.op   = OP_PEN_UP_LAST;
            end else if (slot == LAST_IDX) begin
                idx_next   = '0;
                round_next = !round_reg;
                q_push     = 1'b1;
                q_cmd.op   = round_reg ? OP_END_SECOND : OP_END_FIRST;
            end else begin
                idx_next   = slot + 1'b1;
                q_push     = 1'b1;
                q_cmd.op   = OP_STORE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            round_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            round_reg <= round_next;
        end
    end

endmodule

>>> rtl/core/tmfc_queue.sv
module tmfc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tmfc_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output tmfc_pkg::cmd_t head_cmd
);
    import tmfc_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/tmfc_back.sv
module tmfc_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  tmfc_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    input  tmfc_pkg::cfg_t     cfg,
    output logic               m_valid,
    input  logic               m_ready,
    output tmfc_pkg::out_item_t m_data
);
    import tmfc_pkg::*;

    back_state_t         state_reg, state_next;
    logic [SAMPLE_W-1:0] xs_reg [SAMPLES_PER_ROUND];
    logic [SAMPLE_W-1:0] ys_reg [SAMPLES_PER_ROUND];
    op_t                 op_reg, op_next;
    logic [IDX_W-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] med_x_reg, med_x_next, med_y_reg, med_y_next;
    logic [SAMPLE_W-1:0] first_x_reg, first_x_next, first_y_reg, first_y_next;
    logic [SAMPLE_W-1:0] avg_x_reg, avg_x_next, avg_y_reg, avg_y_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    out_item_t           res_reg, res_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic                store_en;
    logic                out_free;
    logic [IDX_W-1:0]    lt_x, le_x, lt_y, le_y;
    logic                hit_x, hit_y;
    logic signed [31:0]  mul_coef;
    logic [SAMPLE_W-1:0] mul_opnd;

    function automatic logic signed [15:0] to_screen(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-16:0] q;
        // Arithmetic shift floors; bump negative values with a remainder to truncate.
        q = (ACC_W-15)'(acc >>> 16) + (ACC_W-15)'(acc[ACC_W-1] && (acc[15:0] != '0));
        if (q > (ACC_W-15)'(32767)) begin
            return 16'sh7fff;
        end else if (q < -(ACC_W-15)'(32768)) begin
            return 16'sh8000;
        end else begin
            return q[15:0];
        end
    endfunction

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign store_en = q_pop && (q_cmd.op != OP_PEN_UP_LAST);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Rank test for one candidate per cycle: it is the median when at most three
    // samples are below it and at least four are at or below it.
    always_comb begin
        lt_x = '0;
        le_x = '0;
        lt_y = '0;
        le_y = '0;
        for (int j = 0; j < SAMPLES_PER_ROUND; j++) begin
            lt_x = lt_x + IDX_W'(xs_reg[j] < xs_reg[cnt_reg]);
            le_x = le_x + IDX_W'(xs_reg[j] <= xs_reg[cnt_reg]);
            lt_y = lt_y + IDX_W'(ys_reg[j] < ys_reg[cnt_reg]);
            le_y = le_y + IDX_W'(ys_reg[j] <= ys_reg[cnt_reg]);
        end
        hit_x = (lt_x <= IDX_W'(SAMPLES_PER_ROUND / 2))
                && (le_x > IDX_W'(SAMPLES_PER_ROUND / 2));
        hit_y = (lt_y <= IDX_W'(SAMPLES_PER_ROUND / 2))
                && (le_y > IDX_W'(SAMPLES_PER_ROUND / 2));
    end

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin
                mul_coef = cfg.coef_x_from_x;
                mul_opnd = avg_x_reg;
            end
            2'd1: begin
                mul_coef = cfg.coef_x_from_y;
                mul_opnd = avg_y_reg;
            end
            2'd2: begin
                mul_coef = cfg.coef_y_from_x;
                mul_opnd = avg_x_reg;
            end
            default: begin
                mul_coef = cfg.coef_y_from_y;
                mul_opnd = avg_y_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    unique case (q_cmd.op)
                        OP_STORE:       state_next = ST_IDLE;
                        OP_END_FIRST,
                        OP_END_SECOND:  state_next = ST_MEDIAN;
                        OP_PEN_UP_LAST: state_next = ST_EMIT;
                    endcase
                end
            end
            ST_MEDIAN: if (cnt_reg == LAST_IDX) state_next = ST_ROUTE;
            ST_ROUTE:  state_next = (op_reg == OP_END_FIRST) ? ST_IDLE : ST_MUL;
            ST_MUL:    state_next = ST_ACC;
            ST_ACC:    state_next = (cnt_reg[1:0] == 2'd3) ? ST_FINAL : ST_MUL;
            ST_FINAL:  state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        med_x_next   = med_x_reg;
        med_y_next   = med_y_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        avg_x_next   = avg_x_reg;
        avg_y_next   = avg_y_reg;
        prod_next    = prod_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    op_next  = q_cmd.op;
                    cnt_next = '0;
                    res_next = '0;
                end
            end
            ST_MEDIAN: begin
                if (hit_x) med_x_next = xs_reg[cnt_reg];
                if (hit_y) med_y_next = ys_reg[cnt_reg];
                cnt_next = cnt_reg + 1'b1;
            end
            ST_ROUTE: begin
                if (op_reg == OP_END_FIRST) begin
                    first_x_next = med_x_reg;
                    first_y_next = med_y_reg;
                end
                avg_x_next = SAMPLE_W'(({1'b0, first_x_reg} + {1'b0, med_x_reg}) >> 1);
                avg_y_next = SAMPLE_W'(({1'b0, first_y_reg} + {1'b0, med_y_reg}) >> 1);
                cnt_next   = '0;
            end
            ST_MUL: begin
                prod_next = mul_coef * $signed({1'b0, mul_opnd});
            end
            ST_ACC: begin
                unique case (cnt_reg[1:0])
                    2'd0:    acc_x_next = ACC_W'(cfg.offset_x) + ACC_W'(prod_reg);
                    2'd1:    acc_x_next = acc_x_reg + ACC_W'(prod_reg);
                    2'd2:    acc_y_next = ACC_W'(cfg.offset_y) + ACC_W'(prod_reg);
                    default: acc_y_next = acc_y_reg + ACC_W'(prod_reg);
                endcase
                cnt_next = cnt_reg + 1'b1;
            end
            ST_FINAL: begin
                res_next.x_coord = to_screen(acc_x_reg);
                res_next.y_coord = to_screen(acc_y_reg);
                res_next.touched = 1'b1;
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_en) begin
            xs_reg[q_cmd.idx] <= q_cmd.x_sample;
            ys_reg[q_cmd.idx] <= q_cmd.y_sample;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        cnt_reg    <= cnt_next;
        med_x_reg  <= med_x_next;
        med_y_reg  <= med_y_next;
        avg_x_reg  <= avg_x_next;
        avg_y_reg  <= avg_y_next;
        prod_reg   <= prod_next;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            first_x_reg <= '0;
            first_y_reg <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            first_x_reg <= first_x_next;
            first_y_reg <= first_y_next;
        end
    end

endmodule

>>> rtl/core/touch_median_filter_calibrate.sv
// Touch panel filter with affine calibration.
// The s_ channel takes one item per touch-converter reading: the X and Y reply
// byte pairs and the pen-down level. Fourteen pen-down items in a row make two
// rounds of seven samples; the per-round medians are averaged and mapped to
// screen coordinates with the six Q16.16 calibration registers. The m_ channel
// then carries one item with touched set. An item with the pen up restarts the
// collection; if it lands on the fourteenth slot, an item with touched clear and
// zero coordinates is given instead.
// The cfg_ channel writes register cfg_index (0 to 5) with cfg_data and is
// always ready; write it only while the block is idle.
// Input items are taken one per cycle while the four-entry command queue has
// room. The back end pops one stored sample at a time, runs the median search
// and routing at each round end and the multiply-accumulate and output at the
// second one; the queue keeps taking items while the back end works.
// m_valid rises once the back end has handled the fourteenth item, later if
// the queue holds a backlog. A stalled receiver holds the result in the
// output register; the queue keeps filling until it is full, then s_ready
// drops.
// Reset clears the counters, the queue, the output and the calibration
// registers to their defaults.
module touch_median_filter_calibrate (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tmfc_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tmfc_pkg::out_item_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import tmfc_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic q_full, q_push, q_pop, q_valid;
    cmd_t push_cmd, head_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_CXX: cfg_next.coef_x_from_x = cfg_data;
                REG_CXY: cfg_next.coef_x_from_y = cfg_data;
                REG_OX:  cfg_next.offset_x      = cfg_data;
                REG_CYX: cfg_next.coef_y_from_x = cfg_data;
                REG_CYY: cfg_next.coef_y_from_y = cfg_data;
                REG_OY:  cfg_next.offset_y      = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef_x_from_x <= CXX_RESET;
            cfg_reg.coef_x_from_y <= CXY_RESET;
            cfg_reg.offset_x      <= OX_RESET;
            cfg_reg.coef_y_from_x <= CYX_RESET;
            cfg_reg.coef_y_from_y <= CYY_RESET;
            cfg_reg.offset_y      <= OY_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tmfc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    tmfc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    tmfc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_cmd   (head_cmd),
        .q_pop   (q_pop),
        .cfg     (cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/core/tmfc_checker.sv
module tmfc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input tmfc_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input tmfc_pkg::out_item_t m_data,
    input logic                cfg_ready
);

    // An item reporting a lifted pen never carries coordinates.
    a_untouched_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.touched |-> m_data.x_coord == 16'sd0 && m_data.y_coord == 16'sd0)
        else $error("untouched result with nonzero coordinates");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // A waiting input item stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("waiting input item changed or dropped");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind touch_median_filter_calibrate tmfc_checker u_checker (.*);

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tmfc_pkg::*;

    localparam int ROUND_ITEMS = 7;
    localparam int TOUCH_ITEMS = 2 * ROUND_ITEMS;
    localparam int DRAIN_CYCLES = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int IDLE_PERCENT = 8;

    // Indexes past the register list; writes to them must change nothing.
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam cfg_t CAL_DEFAULTS = '{CXX_RESET, CXY_RESET, OX_RESET,
                                      CYX_RESET, CYY_RESET, OY_RESET};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    touch_median_filter_calibrate u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Shadow of the block: calibration and collection state.
    cfg_t             cal_model = CAL_DEFAULTS;
    logic [6:0][11:0] x_round_samples = '0;
    logic [6:0][11:0] y_round_samples = '0;
    logic [11:0]      x_first_median = '0;
    logic [11:0]      y_first_median = '0;
    int               sample_slot = 0;
    bit               second_round = 1'b0;

    out_item_t expected_points[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        steady_mode = 1'b0;
    int        long_holds_asked = 0;

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic logic [11:0] median_of_seven(input logic [6:0][11:0] vals);
        logic [11:0] tmp;
        for (int a = 0; a < ROUND_ITEMS; a++) begin
            for (int b = 0; b < ROUND_ITEMS - 1 - a; b++) begin
                if (vals[b] > vals[b + 1]) begin
                    tmp = vals[b];
                    vals[b] = vals[b + 1];
                    vals[b + 1] = tmp;
                end
            end
        end
        return vals[ROUND_ITEMS / 2];
    endfunction

    // Q16.16 affine term, divided with truncation toward zero, then clamped.
    function automatic logic signed [15:0] calibrate_axis(input logic signed [31:0] w_x,
                                                          input logic signed [31:0] w_y,
                                                          input logic signed [31:0] ofs,
                                                          input logic [11:0] raw_x,
                                                          input logic [11:0] raw_y);
        longint sum;
        longint q;
        sum = longint'(w_x) * longint'(raw_x) + longint'(w_y) * longint'(raw_y)
              + longint'(ofs);
        q = sum / 65536;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return 16'(q);
    endfunction

    task automatic predict_touch_point(input in_item_t it);
        bit          closing_item;
        logic [11:0] x_mid;
        logic [11:0] y_mid;
        logic [12:0] x_sum;
        logic [12:0] y_sum;
        out_item_t   point;
        closing_item = second_round && (sample_slot >= ROUND_ITEMS - 1);
        if (!it.pen_down) begin
            sample_slot = 0;
            second_round = 1'b0;
            if (closing_item) begin
                point = '0;
                expected_points.push_back(point);
            end
            return;
        end
        if (sample_slot >= ROUND_ITEMS) sample_slot = 0;
        x_round_samples[sample_slot] = {it.x_high_byte[6:0], it.x_low_byte[7:3]};
        y_round_samples[sample_slot] = {it.y_high_byte[6:0], it.y_low_byte[7:3]};
        sample_slot++;
        if (sample_slot < ROUND_ITEMS) return;
        x_mid = median_of_seven(x_round_samples);
        y_mid = median_of_seven(y_round_samples);
        sample_slot = 0;
        if (!second_round) begin
            x_first_median = x_mid;
            y_first_median = y_mid;
            second_round = 1'b1;
            return;
        end
        second_round = 1'b0;
        x_sum = {1'b0, x_first_median} + {1'b0, x_mid};
        y_sum = {1'b0, y_first_median} + {1'b0, y_mid};
        point.x_coord = calibrate_axis(cal_model.coef_x_from_x, cal_model.coef_x_from_y,
                                       cal_model.offset_x, x_sum[12:1], y_sum[12:1]);
        point.y_coord = calibrate_axis(cal_model.coef_y_from_x, cal_model.coef_y_from_y,
                                       cal_model.offset_y, x_sum[12:1], y_sum[12:1]);
        point.touched = 1'b1;
        expected_points.push_back(point);
    endtask

    task automatic offer_reading(input in_item_t it);
        while (!steady_mode && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_data <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_touch_point(it);
    endtask

    // Leaves cfg_valid high so that writes can follow back to back.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_CXX: cal_model.coef_x_from_x = value;
            REG_CXY: cal_model.coef_x_from_y = value;
            REG_OX:  cal_model.offset_x = value;
            REG_CYX: cal_model.coef_y_from_x = value;
            REG_CYY: cal_model.coef_y_from_y = value;
            REG_OY:  cal_model.offset_y = value;
            default: ;
        endcase
    endtask

    task automatic program_calibration(input cfg_t c, input bit add_spare_writes);
        write_register(REG_CXX, c.coef_x_from_x);
        if (add_spare_writes) write_register(REG_SPARE_LO, $urandom);
        write_register(REG_CXY, c.coef_x_from_y);
        write_register(REG_OX, c.offset_x);
        write_register(REG_CYX, c.coef_y_from_x);
        if (add_spare_writes) write_register(REG_SPARE_HI, $urandom);
        write_register(REG_CYY, c.coef_y_from_y);
        write_register(REG_OY, c.offset_y);
        cfg_valid <= 1'b0;
    endtask

    // Results only come on the last item of a touch, so items that end no touch
    // may still be in the pipeline after the queue empties; give them time.
    task automatic wait_until_drained();
        s_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [15:0] encode_reply(input logic [11:0] sample);
        return {1'($urandom_range(1)), sample[11:5], sample[4:0], 3'($urandom_range(7))};
    endfunction

    function automatic in_item_t random_reading(input bit clustered,
                                                input logic [11:0] x_center,
                                                input logic [11:0] y_center);
        in_item_t    it;
        logic [15:0] x_word;
        logic [15:0] y_word;
        if (clustered) begin
            x_word = encode_reply(x_center + 12'($urandom_range(40)) - 12'd20);
            y_word = encode_reply(y_center + 12'($urandom_range(40)) - 12'd20);
        end else begin
            x_word = 16'($urandom);
            y_word = 16'($urandom);
        end
        it.x_high_byte = x_word[15:8];
        it.x_low_byte = x_word[7:0];
        it.y_high_byte = y_word[15:8];
        it.y_low_byte = y_word[7:0];
        it.pen_down = 1'b1;
        return it;
    endfunction

    // One touch of fourteen items. When breaks are allowed, some touches are
    // preceded by stray pen-up items or cut short by a lift of the pen.
    task automatic send_touch(input bit allow_breaks);
        in_item_t    it;
        bit          clustered;
        logic [11:0] x_center;
        logic [11:0] y_center;
        int          lift_at;
        int          roll;
        clustered = $urandom_range(1);
        x_center = 12'($urandom);
        y_center = 12'($urandom);
        lift_at = -1;
        roll = $urandom_range(99);
        if (allow_breaks && roll < 12) begin
            lift_at = $urandom_range(TOUCH_ITEMS - 1);
        end else if (allow_breaks && roll < 20) begin
            repeat ($urandom_range(1, 3)) begin
                it = random_reading(1'b0, x_center, y_center);
                it.pen_down = 1'b0;
                offer_reading(it);
            end
        end
        for (int n = 0; n < TOUCH_ITEMS; n++) begin
            it = random_reading(clustered, x_center, y_center);
            if (n == lift_at) it.pen_down = 1'b0;
            offer_reading(it);
            if (n == lift_at) break;
        end
    endtask

    function automatic cfg_t random_calibration(input bit full_range);
        cfg_t c;
        if (full_range) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            c.coef_x_from_x = 32'($urandom_range(40000)) - 32'd20000;
            c.coef_x_from_y = 32'($urandom_range(4000)) - 32'd2000;
            c.offset_x = 32'($urandom_range(1 << 26)) - 32'(1 << 25);
            c.coef_y_from_x = 32'($urandom_range(4000)) - 32'd2000;
            c.coef_y_from_y = 32'($urandom_range(40000)) - 32'd20000;
            c.offset_y = 32'($urandom_range(1 << 26)) - 32'(1 << 25);
        end
        return c;
    endfunction

    task automatic test_field_extremes();
        logic [7:0] high_picks [7];
        logic [7:0] low_picks [7];
        in_item_t   it;
        high_picks = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55};
        low_picks = '{8'h00, 8'hFF, 8'h07, 8'hF8, 8'h08, 8'h10, 8'hAA};
        for (int n = 0; n < TOUCH_ITEMS; n++) begin
            it.x_high_byte = high_picks[n % 7];
            it.x_low_byte = low_picks[(n + 2) % 7];
            it.y_high_byte = high_picks[(6 - n % 7 + n / 7) % 7];
            it.y_low_byte = low_picks[(n * 3) % 7];
            it.pen_down = 1'b1;
            offer_reading(it);
        end
    endtask

    task automatic test_pen_up_cases();
        in_item_t it;
        // A lift early in the first round discards what was collected.
        for (int n = 0; n < 4; n++) begin
            it = random_reading(1'b0, '0, '0);
            it.pen_down = (n != 3);
            offer_reading(it);
        end
        // A lift on the last item of a touch gives an untouched result.
        for (int n = 0; n < TOUCH_ITEMS; n++) begin
            it = random_reading(1'b0, '0, '0);
            it.pen_down = (n != TOUCH_ITEMS - 1);
            offer_reading(it);
        end
    endtask

    task automatic test_calibration_extremes();
        cfg_t c;
        wait_until_drained();
        c = {6{32'h7FFF_FFFF}};
        program_calibration(c, 1'b1);
        repeat (2) send_touch(1'b0);
        wait_until_drained();
        c = {6{32'h8000_0000}};
        program_calibration(c, 1'b0);
        repeat (2) send_touch(1'b0);
        wait_until_drained();
        // Unit and negated unit gains with offsets just short of one pixel.
        c = '{32'sd65536, 32'sd0, -32'sd65535, 32'sd0, -32'sd65536, 32'sd65535};
        program_calibration(c, 1'b1);
        repeat (2) send_touch(1'b0);
        wait_until_drained();
        c = '0;
        program_calibration(c, 1'b0);
        send_touch(1'b0);
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            wait_until_drained();
            case (phase)
                0:       program_calibration(CAL_DEFAULTS, 1'b0);
                2:       program_calibration(random_calibration(1'b1), 1'b1);
                default: program_calibration(random_calibration(1'b0), 1'b0);
            endcase
            repeat (8) send_touch(1'b1);
        end
    endtask

    task automatic test_output_backpressure();
        long_holds_asked <= long_holds_asked + 1;
        repeat (3) send_touch(1'b0);
    endtask

    task automatic test_steady_stream();
        steady_mode <= 1'b1;
        repeat (6) send_touch(1'b1);
        steady_mode <= 1'b0;
    endtask

    initial begin : result_receiver
        int holds_seen;
        int hold_left;
        holds_seen = 0;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (long_holds_asked != holds_seen) begin
                holds_seen = long_holds_asked;
                hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (steady_mode) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge aclk) begin : result_checker
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch($sformatf("unexpected result x=%0d y=%0d touched=%0b",
                                          m_data.x_coord, m_data.y_coord, m_data.touched));
            end else begin
                want = expected_points.pop_front();
                if (m_data.x_coord !== want.x_coord)
                    report_mismatch($sformatf("x_coord %0d, expected %0d",
                                              m_data.x_coord, want.x_coord));
                if (m_data.y_coord !== want.y_coord)
                    report_mismatch($sformatf("y_coord %0d, expected %0d",
                                              m_data.y_coord, want.y_coord));
                if (m_data.touched !== want.touched)
                    report_mismatch($sformatf("touched %0b, expected %0b",
                                              m_data.touched, want.touched));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : main_sequence
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_pen_up_cases();
        test_calibration_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_steady_stream();
        wait_until_drained();
        while (expected_points.size() != 0) begin
            report_mismatch($sformatf("missing result x=%0d y=%0d touched=%0b",
                                      expected_points[0].x_coord, expected_points[0].y_coord,
                                      expected_points[0].touched));
            void'(expected_points.pop_front());
        end
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/tmfc_pkg.sv
rtl/core/tmfc_front.sv
rtl/core/tmfc_queue.sv
rtl/core/tmfc_back.sv
rtl/core/touch_median_filter_calibrate.sv
rtl/core/tmfc_checker.sv
test/testbench.sv
